@@ design/tt_pkg.sv @@
// ----------------------------------------------------------------------------
// tt_pkg
// Shared types and constants of the table transliterator.
// ----------------------------------------------------------------------------
`default_nettype none

package tt_pkg;

	localparam int CP_W  = 21;
	localparam int LEN_W = 3;
	localparam int NSP   = 4;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_FWD   = 2'd2,
		OP_REV   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_CHAR   = 2'd0,
		ST_STORED = 2'd1,
		ST_DUP    = 2'd2,
		ST_FULL   = 2'd3
	} stat_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic append;
		logic scan_init;
		logic scan_rd;
		logic load_commit;
		logic emit_sym;
		logic fwd_emit;
		logic rev_commit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_done;
		logic can_emit;
		logic fhit;
		logic fwd_more;
		logic rev_go;
	} sts_t;

endpackage

`default_nettype wire

@@ design/table_transliterator.sv @@
// ----------------------------------------------------------------------------
// table_transliterator
// Code-point transliteration through a loaded table, forward and reverse.
//
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | operation, symbol, spell_char_0..3,
//         |                      | spell_length, word_end
// output  | out_valid / out_ready| out_char, status, run_last
//
// Load and forward map scan the table one entry per cycle through the RAM read
// port; a forward hit then emits each spelling character in turn. Reverse map
// scans once, then once more per emitted character, so up to CAP + 1 scans per
// transfer, where CAP is the smaller of MAX_SPELL and 4.
// Reset clears the valid bits, entry count and window; no clearing pass.
// A stalled output holds the sequencer at its next emission.
// ----------------------------------------------------------------------------
`default_nettype none

module table_transliterator import tt_pkg::*; #(
	parameter int MAX_ENTRIES = 32,
	parameter int MAX_SPELL   = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       operation,
	input  wire logic [CP_W-1:0]  symbol,
	input  wire logic [CP_W-1:0]  spell_char_0,
	input  wire logic [CP_W-1:0]  spell_char_1,
	input  wire logic [CP_W-1:0]  spell_char_2,
	input  wire logic [CP_W-1:0]  spell_char_3,
	input  wire logic [LEN_W-1:0] spell_length,
	input  wire logic             word_end,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [CP_W-1:0]       out_char,
	output logic [1:0]            status,
	output logic                  run_last
);

	cmd_t cmd;
	sts_t sts;

	tt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tt_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_SPELL   (MAX_SPELL)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.symbol       (symbol),
		.spell_char_0 (spell_char_0),
		.spell_char_1 (spell_char_1),
		.spell_char_2 (spell_char_2),
		.spell_char_3 (spell_char_3),
		.spell_length (spell_length),
		.word_end     (word_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.status       (status),
		.run_last     (run_last),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

`default_nettype wire

@@ design/tt_ram.sv @@
// ----------------------------------------------------------------------------
// tt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                         clk,
	input  wire logic                                         wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                             wr_data,
	input  wire logic                                         rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/tt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tt_ctrl
// Sequencer: table scans, load commit, forward and reverse emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tt_ctrl import tt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_DECIDE,
		S_FEMIT,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
			end
			S_START: begin
				case (sts.op)
					OP_CLEAR: cmd.clear = 1'b1;
					OP_REV: begin
						cmd.append    = 1'b1;
						cmd.scan_init = 1'b1;
					end
					default: cmd.scan_init = 1'b1;
				endcase
			end
			S_SCAN: begin
				cmd.scan_rd = !sts.scan_done;
			end
			S_DECIDE: begin
				case (sts.op)
					OP_LOAD: cmd.load_commit = sts.can_emit;
					OP_FWD:  cmd.emit_sym = !sts.fhit && sts.can_emit;
					OP_REV: begin
						cmd.rev_commit = sts.rev_go && sts.can_emit;
						cmd.scan_init  = sts.rev_go && sts.can_emit;
					end
					default: ;
				endcase
			end
			S_FEMIT: begin
				cmd.fwd_emit = sts.fwd_more && sts.can_emit;
			end
			S_FINISH: begin
				cmd.finish = sts.can_emit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_START;
				S_START: state_q <= (sts.op == OP_CLEAR) ? S_IDLE : S_SCAN;
				S_SCAN: if (sts.scan_done) state_q <= S_DECIDE;
				S_DECIDE: begin
					case (sts.op)
						OP_LOAD: if (sts.can_emit) state_q <= S_FINISH;
						OP_FWD: begin
							if (sts.fhit) state_q <= S_FEMIT;
							else if (sts.can_emit) state_q <= S_FINISH;
						end
						OP_REV: begin
							if (!sts.rev_go) state_q <= S_FINISH;
							else if (sts.can_emit) state_q <= S_SCAN;
						end
						default: state_q <= S_FINISH;
					endcase
				end
				S_FEMIT: if (!sts.fwd_more) state_q <= S_FINISH;
				S_FINISH: if (sts.can_emit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/tt_dp.sv @@
// ----------------------------------------------------------------------------
// tt_dp
// Datapath: entry table, valid bits, match window, scan compare, result hold
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tt_dp import tt_pkg::*; #(
	parameter int MAX_ENTRIES = 32,
	parameter int MAX_SPELL   = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        operation,
	input  wire logic [CP_W-1:0]   symbol,
	input  wire logic [CP_W-1:0]   spell_char_0,
	input  wire logic [CP_W-1:0]   spell_char_1,
	input  wire logic [CP_W-1:0]   spell_char_2,
	input  wire logic [CP_W-1:0]   spell_char_3,
	input  wire logic [LEN_W-1:0]  spell_length,
	input  wire logic              word_end,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CP_W-1:0]        out_char,
	output logic [1:0]             status,
	output logic                   run_last,
	input  wire cmd_t              cmd,
	output sts_t                   sts
);

	localparam int CAP = (MAX_SPELL < NSP) ? MAX_SPELL : NSP;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int DW  = CP_W * (CAP + 1) + LEN_W;
	localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAP);

	op_t              op_q;
	logic [CP_W-1:0]  sym_q;
	logic [CP_W-1:0]  sp_q [NSP];
	logic [LEN_W-1:0] len_q;
	logic             wend_q;

	logic [MAX_ENTRIES-1:0] fvalid_q;
	logic [MAX_ENTRIES-1:0] rvalid_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          addr_q;
	logic [AW-1:0]          addr_s1;
	logic                   cmp_v_s1;

	logic [CP_W-1:0]  win_q [NSP];
	logic [LEN_W-1:0] pend_q;

	logic             fhit_q;
	logic             rvhit_q;
	logic [CP_W-1:0]  fsp_q [NSP];
	logic [LEN_W-1:0] flen_q;
	logic [LEN_W-1:0] k_q;
	logic [NSP-1:0]   hit_v_q;
	logic [CP_W-1:0]  hit_key_q [NSP];

	logic             held_v_q;
	logic [CP_W-1:0]  held_char_q;
	stat_t            held_stat_q;

	logic [CP_W-1:0]  sp_in [NSP];
	logic [LEN_W-1:0] len_in;
	logic             ram_we;
	logic [DW-1:0]    ram_wdata;
	logic [DW-1:0]    ram_rdata;
	logic [CP_W-1:0]  e_key;
	logic [CP_W-1:0]  e_sp [NSP];
	logic [LEN_W-1:0] e_len;
	logic             fv;
	logic             rv;
	logic             key_eq;
	logic             lmatch;
	logic [NSP-1:0]   wmatch;
	logic             full;
	stat_t            load_stat;
	logic [1:0]       sel;
	logic             any_hit;
	logic [LEN_W-1:0] drop;
	logic             emit;
	logic [CP_W-1:0]  new_char;
	stat_t            new_stat;
	logic             can_emit;
	logic             push;

	assign sp_in[0] = spell_char_0;
	assign sp_in[1] = spell_char_1;
	assign sp_in[2] = spell_char_2;
	assign sp_in[3] = spell_char_3;

	always_comb begin
		len_in = spell_length;
		if (len_in == '0) len_in = LEN_W'(1);
		if (len_in > CAP_L) len_in = CAP_L;
	end

	always_comb begin
		ram_wdata = '0;
		ram_wdata[CP_W-1:0] = sym_q;
		for (int k = 0; k < CAP; k++) begin
			ram_wdata[CP_W*(k+1) +: CP_W] = sp_q[k];
		end
		ram_wdata[DW-1 -: LEN_W] = len_q;
	end

	assign full      = (count_q >= CW'(MAX_ENTRIES));
	assign load_stat = (fhit_q && rvhit_q) ? ST_DUP : (full ? ST_FULL : ST_STORED);
	assign ram_we    = cmd.load_commit && !(fhit_q && rvhit_q) && !full;

	tt_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ENTRIES)
	) u_tbl (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (ram_wdata),
		.rd_en   (cmd.scan_rd),
		.rd_addr (addr_q[AW-1:0]),
		.rd_data (ram_rdata)
	);

	always_comb begin
		e_key = ram_rdata[CP_W-1:0];
		for (int k = 0; k < NSP; k++) begin
			e_sp[k] = '0;
		end
		for (int k = 0; k < CAP; k++) begin
			e_sp[k] = ram_rdata[CP_W*(k+1) +: CP_W];
		end
		e_len = ram_rdata[DW-1 -: LEN_W];
	end

	assign fv     = fvalid_q[addr_s1];
	assign rv     = rvalid_q[addr_s1];
	assign key_eq = (e_key == sym_q);

	always_comb begin
		lmatch = (e_len == len_q);
		for (int k = 0; k < CAP; k++) begin
			if ((LEN_W'(k) < len_q) && (e_sp[k] != sp_q[k])) lmatch = 1'b0;
		end
	end

	always_comb begin
		wmatch = '0;
		for (int l = 1; l <= CAP; l++) begin
			wmatch[l-1] = rv && (e_len == LEN_W'(l)) && (LEN_W'(l) <= pend_q);
			for (int k = 0; k < l; k++) begin
				if (e_sp[k] != win_q[k]) wmatch[l-1] = 1'b0;
			end
		end
	end

	always_comb begin
		sel     = '0;
		any_hit = |hit_v_q;
		for (int l = NSP - 1; l >= 0; l--) begin
			if (hit_v_q[l]) sel = 2'(l);
		end
		drop = any_hit ? (LEN_W'(sel) + LEN_W'(1)) : LEN_W'(1);
	end

	assign emit = cmd.load_commit || cmd.emit_sym || cmd.fwd_emit || cmd.rev_commit;

	always_comb begin
		new_char = '0;
		new_stat = ST_CHAR;
		if (cmd.load_commit) begin
			new_stat = load_stat;
		end else if (cmd.emit_sym) begin
			new_char = sym_q;
		end else if (cmd.fwd_emit) begin
			new_char = fsp_q[k_q[1:0]];
		end else if (cmd.rev_commit) begin
			new_char = any_hit ? hit_key_q[sel] : win_q[0];
		end
	end

	assign can_emit = !held_v_q || !out_valid || out_ready;
	assign push     = held_v_q && (emit || cmd.finish);

	assign sts.op        = op_q;
	assign sts.scan_done = (addr_q >= count_q);
	assign sts.can_emit  = can_emit;
	assign sts.fhit      = fhit_q;
	assign sts.fwd_more  = (k_q < flen_q);
	assign sts.rev_go    = (pend_q != '0) && (any_hit || (pend_q >= CAP_L) || wend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= OP_CLEAR;
			fvalid_q  <= '0;
			rvalid_q  <= '0;
			count_q   <= '0;
			addr_q    <= '0;
			cmp_v_s1  <= 1'b0;
			pend_q    <= '0;
			fhit_q    <= 1'b0;
			rvhit_q   <= 1'b0;
			hit_v_q   <= '0;
			k_q       <= '0;
			held_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.capture) op_q <= op_t'(operation);
			cmp_v_s1 <= cmd.scan_rd;
			if (cmd.scan_rd) addr_q <= addr_q + CW'(1);
			if (cmd.fwd_emit) k_q <= k_q + LEN_W'(1);
			if (cmp_v_s1) begin
				if (fv && key_eq) fhit_q <= 1'b1;
				if (rv && lmatch) rvhit_q <= 1'b1;
				hit_v_q <= hit_v_q | wmatch;
			end
			if (cmd.append && (pend_q < CAP_L)) pend_q <= pend_q + LEN_W'(1);
			if (cmd.rev_commit) pend_q <= pend_q - drop;
			if (cmd.scan_init) begin
				addr_q  <= '0;
				fhit_q  <= 1'b0;
				rvhit_q <= 1'b0;
				hit_v_q <= '0;
				k_q     <= '0;
			end
			if (ram_we) begin
				fvalid_q[count_q[AW-1:0]] <= !fhit_q;
				rvalid_q[count_q[AW-1:0]] <= !rvhit_q;
				count_q <= count_q + CW'(1);
			end
			if (cmd.clear) begin
				fvalid_q <= '0;
				rvalid_q <= '0;
				count_q  <= '0;
				pend_q   <= '0;
			end
			if (emit) held_v_q <= 1'b1;
			else if (cmd.finish) held_v_q <= 1'b0;
			if (push) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q[AW-1:0];
		if (cmd.capture) begin
			sym_q  <= symbol;
			len_q  <= len_in;
			wend_q <= word_end;
			for (int k = 0; k < NSP; k++) begin
				sp_q[k] <= sp_in[k];
			end
		end
		if (cmp_v_s1) begin
			if (fv && key_eq && !fhit_q) begin
				flen_q <= e_len;
				for (int k = 0; k < NSP; k++) begin
					fsp_q[k] <= e_sp[k];
				end
			end
			for (int l = 0; l < NSP; l++) begin
				if (wmatch[l] && !hit_v_q[l]) hit_key_q[l] <= e_key;
			end
		end
		if (cmd.append && (pend_q < CAP_L)) win_q[pend_q[1:0]] <= sym_q;
		if (cmd.rev_commit) begin
			for (int k = 0; k < NSP; k++) begin
				if ((LEN_W'(k) + drop) < LEN_W'(NSP)) begin
					win_q[k] <= win_q[2'(LEN_W'(k) + drop)];
				end
			end
		end
		if (emit) begin
			held_char_q <= new_char;
			held_stat_q <= new_stat;
		end
		if (push) begin
			out_char <= held_char_q;
			status   <= held_stat_q;
			run_last <= cmd.finish;
		end
	end

`ifndef NO_ASSERTIONS
	a_pend_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CAP_L) else $error("window count above capacity");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES)) else $error("entry count above table size");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid || out_ready)) else $error("result overwritten");
	a_finish_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !held_v_q) else $error("held result left after finish");
`endif

endmodule

`default_nettype wire
